// File: rtl/lhh_pkg.sv
`default_nettype none

package lhh_pkg;

    // Item kinds
    localparam logic [1:0] KIND_AUDIO = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int BLOCK_W = 14;
    localparam int LOUD_W  = 16;
    localparam int BIN_W   = 7;
    localparam int CNT_W   = 10;
    localparam int SPT_W   = 16;

    // Histogram geometry, quantizer offset of +70 LU in 1/16 LU
    localparam int               NUM_BINS   = 71;
    localparam logic [BIN_W-1:0] TOP_BIN    = 7'd70;
    localparam logic [16:0]      LOUD_OFS   = 17'd1120;

    // Defaults
    localparam logic [SPT_W-1:0] SPT_RESET       = 16'd4800;
    localparam int               DEF_HIST_DEPTH  = 512;
    localparam int               DEF_MAX_BLOCK   = 8192;

    // round(loudness + 70) with halves away from zero, clamped to 0..70
    function automatic logic [BIN_W-1:0] quantize(input logic signed [LOUD_W-1:0] loud);
        logic signed [16:0] x;
        logic        [16:0] r;
        logic        [12:0] y;
        x = 17'(loud) + $signed(LOUD_OFS);
        r = 17'(x) + 17'd8;
        y = r[16:4];
        if (x < 0)
            quantize = '0;
        else if (y > 13'(TOP_BIN))
            quantize = TOP_BIN;
        else
            quantize = y[BIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/loudness_history_histogram.sv
// Flow: read-bin items pass S_READ, then S_FINISH; clear items only S_FINISH.
//   Audio items walk their completed periods in S_TICK, rebuild the histogram
//   in S_SCAN if any (one filled slot per cycle via the read pipeline), then
//   S_FINISH. Throughput: one item at a time; the next item is taken once the
//   current one has finished. Reset (rst_n low, asynchronous) empties history
//   and histogram and loads samples_per_tick = 4800.
`default_nettype none

module loudness_history_histogram
    import lhh_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HIST_DEPTH,
    parameter int MAX_BLOCK     = DEF_MAX_BLOCK
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration: samples_per_tick
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SPT_W-1:0]  cfg_data,
    // input items
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [39:0]       s_tdata,  // block_samples, loudness_q4, bin_select, zero pad
    input  wire logic [KIND_W-1:0] s_tuser,  // kind
    // result items
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,  // bin_count, max_count, modal_bin, zero pad
    output logic                   m_tuser   // updated
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam logic [31:0] MAX_BLOCK_L = 32'(MAX_BLOCK);

    typedef enum logic [2:0] {S_IDLE, S_TICK, S_SCAN, S_READ, S_FINISH} state_t;

    state_t                  state_reg;
    logic [SPT_W-1:0]        spt_reg;
    logic [SPT_W-1:0]        phase_reg;
    logic [SLOT_W-1:0]       wslot_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [BLOCK_W-1:0]      left_reg;
    logic [BIN_W-1:0]        q_reg;
    logic                    upd_reg;
    logic [FILL_W-1:0]       rd_idx_reg;
    logic                    b_valid_reg;
    logic                    c_valid_reg;
    logic [BIN_W-1:0]        c_bin_reg;
    logic                    fwd_valid_reg;
    logic [BIN_W-1:0]        fwd_bin_reg;
    logic [CW-1:0]           fwd_val_reg;
    logic [NUM_BINS-1:0]     bin_valid_reg;
    logic [CW-1:0]           peak_cnt_reg;
    logic [BIN_W-1:0]        peak_bin_reg;
    logic [BIN_W-1:0]        sel_reg;
    logic                    sel_ok_reg;
    logic [CW-1:0]           res_cnt_reg;
    logic                    out_valid_reg;
    logic                    out_upd_reg;
    logic [CNT_W-1:0]        out_cnt_reg;
    logic [CNT_W-1:0]        out_max_reg;
    logic [BIN_W-1:0]        out_modal_reg;

    // memories and their registered read data
    logic [BIN_W-1:0]        hist_mem [HISTORY_DEPTH];
    logic [CW-1:0]           cnt_mem  [NUM_BINS];
    logic [BIN_W-1:0]        hist_rd_reg;
    logic [CW-1:0]           cnt_rd_reg;

    // input fields
    logic [BLOCK_W-1:0]      in_block;
    logic signed [LOUD_W-1:0] in_loud;
    logic [BIN_W-1:0]        in_sel;
    logic                    in_take;
    logic [BLOCK_W-1:0]      block_clamped;

    assign in_block = s_tdata[13:0];
    assign in_loud  = s_tdata[29:14];
    assign in_sel   = s_tdata[36:30];
    assign in_take  = s_tvalid && s_tready;
    assign block_clamped = (32'(in_block) > MAX_BLOCK_L) ? MAX_BLOCK_L[BLOCK_W-1:0] : in_block;

    // samples needed to reach the next period boundary
    logic [16:0] phase_p1;
    logic [16:0] tick_len;
    logic        tick_hit;

    assign phase_p1 = {1'b0, phase_reg} + 17'd1;
    assign tick_len = (phase_p1 >= {1'b0, spt_reg}) ? 17'd1
                    : ({1'b0, spt_reg} - {1'b0, phase_reg});
    assign tick_hit = ({3'b000, left_reg} >= tick_len);

    // rebuild scan pipeline: issue history read, read bin count, write back
    logic             scan_issue;
    logic             scan_done;
    logic [BIN_W-1:0] b_bin;
    logic [CW-1:0]    cnt_base;
    logic [CW-1:0]    cnt_cur;
    logic [CW-1:0]    cnt_inc;
    logic [BIN_W-1:0] cnt_raddr;
    logic [BIN_W-1:0] sel_clamped;

    assign scan_issue = (state_reg == S_SCAN) && (rd_idx_reg < fill_reg);
    assign scan_done  = !scan_issue && !b_valid_reg && !c_valid_reg;
    assign b_bin      = (hist_rd_reg > TOP_BIN) ? TOP_BIN : hist_rd_reg;
    assign cnt_base   = bin_valid_reg[c_bin_reg] ? cnt_rd_reg : '0;
    assign cnt_cur    = (fwd_valid_reg && (fwd_bin_reg == c_bin_reg)) ? fwd_val_reg : cnt_base;
    assign cnt_inc    = cnt_cur + CW'(1);
    assign sel_clamped = (in_sel > TOP_BIN) ? TOP_BIN : in_sel;
    assign cnt_raddr  = (state_reg == S_IDLE) ? sel_clamped : b_bin;

    // history memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TICK && tick_hit)
            hist_mem[wslot_reg] <= q_reg;
        hist_rd_reg <= hist_mem[rd_idx_reg[SLOT_W-1:0]];
    end

    // bin count memory
    always_ff @(posedge clk)
    begin
        if (c_valid_reg)
            cnt_mem[c_bin_reg] <= cnt_inc;
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    // output masking to field width
    logic [CW+CNT_W-1:0] res_wide;
    logic [CW+CNT_W-1:0] peak_wide;

    assign res_wide  = {{CNT_W{1'b0}}, res_cnt_reg};
    assign peak_wide = {{CNT_W{1'b0}}, peak_cnt_reg};

    // control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            spt_reg       <= SPT_RESET;
            phase_reg     <= '0;
            wslot_reg     <= '0;
            fill_reg      <= '0;
            left_reg      <= '0;
            q_reg         <= '0;
            upd_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            c_bin_reg     <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_bin_reg   <= '0;
            fwd_val_reg   <= '0;
            bin_valid_reg <= '0;
            peak_cnt_reg  <= '0;
            peak_bin_reg  <= '0;
            sel_reg       <= '0;
            sel_ok_reg    <= 1'b0;
            res_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_upd_reg   <= 1'b0;
            out_cnt_reg   <= '0;
            out_max_reg   <= '0;
            out_modal_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                spt_reg <= cfg_data;

            // the finish state handles the result register itself
            if (m_tready && (state_reg != S_FINISH))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        upd_reg     <= 1'b0;
                        res_cnt_reg <= '0;
                        priority if (s_tuser == KIND_AUDIO)
                        begin
                            left_reg  <= block_clamped;
                            q_reg     <= quantize(in_loud);
                            state_reg <= S_TICK;
                        end
                        else if (s_tuser == KIND_READ)
                        begin
                            sel_reg    <= sel_clamped;
                            sel_ok_reg <= (in_sel <= TOP_BIN);
                            state_reg  <= S_READ;
                        end
                        else if (s_tuser == KIND_CLEAR)
                        begin
                            phase_reg <= '0;
                            wslot_reg <= '0;
                            fill_reg  <= '0;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end

                // one completed period per cycle
                S_TICK:
                begin
                    if (tick_hit)
                    begin
                        left_reg  <= left_reg - tick_len[BLOCK_W-1:0];
                        phase_reg <= '0;
                        wslot_reg <= (wslot_reg == SLOT_W'(HISTORY_DEPTH - 1))
                                     ? '0 : wslot_reg + SLOT_W'(1);
                        if (fill_reg != FILL_W'(HISTORY_DEPTH))
                            fill_reg <= fill_reg + FILL_W'(1);
                        upd_reg   <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + SPT_W'(left_reg);
                        left_reg  <= '0;
                        if (upd_reg)
                        begin
                            rd_idx_reg    <= '0;
                            b_valid_reg   <= 1'b0;
                            c_valid_reg   <= 1'b0;
                            fwd_valid_reg <= 1'b0;
                            bin_valid_reg <= '0;
                            peak_cnt_reg  <= '0;
                            peak_bin_reg  <= '0;
                            state_reg     <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end

                // histogram rebuild over slots 0..fill-1
                S_SCAN:
                begin
                    if (scan_issue)
                        rd_idx_reg <= rd_idx_reg + FILL_W'(1);
                    b_valid_reg   <= scan_issue;
                    c_valid_reg   <= b_valid_reg;
                    c_bin_reg     <= b_bin;
                    fwd_valid_reg <= c_valid_reg;
                    fwd_bin_reg   <= c_bin_reg;
                    fwd_val_reg   <= cnt_inc;
                    if (c_valid_reg)
                    begin
                        bin_valid_reg[c_bin_reg] <= 1'b1;
                        if (cnt_inc > peak_cnt_reg)
                        begin
                            peak_cnt_reg <= cnt_inc;
                            peak_bin_reg <= c_bin_reg;
                        end
                    end
                    if (scan_done)
                        state_reg <= S_FINISH;
                end

                S_READ:
                begin
                    res_cnt_reg <= (sel_ok_reg && bin_valid_reg[sel_reg]) ? cnt_rd_reg : '0;
                    state_reg   <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_upd_reg   <= upd_reg;
                        out_cnt_reg   <= res_wide[CNT_W-1:0];
                        out_max_reg   <= peak_wide[CNT_W-1:0];
                        out_modal_reg <= peak_bin_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_upd_reg;
    assign m_tdata   = {5'b00000, out_modal_reg, out_max_reg, out_cnt_reg};

    // fill count never passes the ring size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(HISTORY_DEPTH))
        else $error("fill count above history depth");

    // count write-back only happens during a rebuild
    a_wb_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (state_reg == S_SCAN))
        else $error("bin count write outside rebuild");

    // scan reads never pass the filled region
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (rd_idx_reg <= fill_reg))
        else $error("scan index past fill count");

    // a new result is only loaded from the finish state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result loaded outside finish state");

    // the peak never exceeds the number of filled slots right after a rebuild
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && scan_done) |=> (peak_cnt_reg <= CW'(fill_reg)))
        else $error("peak count above fill count");

endmodule

`default_nettype wire

// File: tb/tb_loudness_history_histogram.sv
`default_nettype none

module tb_loudness_history_histogram;
    import lhh_pkg::*;

    // kind 3 is not decoded by the block: no state change, result as for a clear
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] blk;
        logic [15:0] loud;
        logic [6:0]  sel;
    } meter_item_t;

    typedef struct packed {
        logic       updated;
        logic [9:0] bin_count;
        logic [9:0] max_count;
        logic [6:0] modal_bin;
    } meter_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // block_samples, loudness_q4, bin_select, zero pad
    logic [1:0]  s_tuser = '0;   // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // bin_count, max_count, modal_bin, zero pad
    logic        m_tuser;        // updated

    loudness_history_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Predicted meter state
    int          tick_period;
    int          ring_phase;
    int          ring_slot;
    int          ring_fill;
    logic [6:0]  ring_bins [DEF_HIST_DEPTH];
    int          tally [NUM_BINS];
    int          peak_tally;
    int          peak_at;

    meter_item_t   pending_items [$];
    meter_result_t expected_results [$];

    // Run bookkeeping
    int fail_count = 0;
    int items_seen = 0;
    int rebuilds_seen = 0;
    int reads_seen = 0;
    int clears_seen = 0;
    int settings_used = 1;
    int deepest_fill = 0;
    int top_peak = 0;

    // Traffic shaping
    bit  item_taken = 1'b0;
    bit  gaps_on = 1'b1;
    int  send_gap = 0;
    int  stall_left = 0;
    int  cluster_bin = 60;
    meter_item_t   next_item;
    meter_result_t got_result;
    meter_result_t want_result;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Advance the predicted meter by one item and queue the result it gives
    task automatic advance_meter(input logic [1:0] kind, input logic [13:0] blk,
                                 input logic [15:0] loud, input logic [6:0] sel);
        int            n;
        int            x;
        int            q;
        int            b;
        meter_result_t r;
        r = '0;
        items_seen++;
        case (kind)
            KIND_AUDIO:
            begin
                // offset by +70 LU, round halves up, clamp to the bin range
                x = int'($signed(loud)) + int'(LOUD_OFS);
                q = (x < 0) ? 0 : ((x + 8) >>> 4);
                if (q > int'(TOP_BIN))
                    q = int'(TOP_BIN);
                n = (int'(blk) > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : int'(blk);
                for (int i = 0; i < n; i++)
                begin
                    ring_phase++;
                    if (ring_phase >= tick_period)
                    begin
                        ring_phase = 0;
                        ring_bins[ring_slot] = 7'(q);
                        ring_slot = (ring_slot + 1) % DEF_HIST_DEPTH;
                        if (ring_fill < DEF_HIST_DEPTH)
                            ring_fill++;
                        r.updated = 1'b1;
                    end
                end
                // rebuild: slot order scan, first bin to pass the running peak wins
                if (r.updated)
                begin
                    rebuilds_seen++;
                    foreach (tally[i])
                        tally[i] = 0;
                    peak_tally = 0;
                    peak_at = 0;
                    for (int i = 0; i < ring_fill; i++)
                    begin
                        b = int'(ring_bins[i]);
                        tally[b]++;
                        if (tally[b] > peak_tally)
                        begin
                            peak_tally = tally[b];
                            peak_at = b;
                        end
                    end
                    if (ring_fill > deepest_fill)
                        deepest_fill = ring_fill;
                    if (peak_tally > top_peak)
                        top_peak = peak_tally;
                end
            end
            KIND_READ:
            begin
                reads_seen++;
                if (int'(sel) < NUM_BINS)
                    r.bin_count = 10'(tally[sel]);
            end
            KIND_CLEAR:
            begin
                clears_seen++;
                ring_phase = 0;
                ring_slot = 0;
                ring_fill = 0;
            end
            default:
            begin
            end
        endcase
        r.max_count = 10'(peak_tally);
        r.modal_bin = 7'(peak_at);
        expected_results.push_back(r);
    endtask

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // Input driver: one item per handshake, random idle bursts between items
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || item_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0 && gaps_on && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 11);
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                next_item = pending_items.pop_front();
                s_tdata <= {3'b000, next_item.sel, next_item.loud, next_item.blk};
                s_tuser <= next_item.kind;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Monitor: register writes, accepted items, result checks
    always @(posedge clk)
    begin
        item_taken = rst_n && s_tvalid && s_tready;
        if (rst_n && cfg_valid && cfg_ready)
            tick_period = int'(cfg_data);
        if (item_taken)
            advance_meter(s_tuser, s_tdata[13:0], s_tdata[29:14], s_tdata[36:30]);
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = {m_tuser, m_tdata[9:0], m_tdata[19:10], m_tdata[26:20]};
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, got_result);
                fail_count++;
            end
            else
            begin
                want_result = expected_results.pop_front();
                check_field("updated", want_result.updated, got_result.updated);
                check_field("bin_count", want_result.bin_count, got_result.bin_count);
                check_field("max_count", want_result.max_count, got_result.max_count);
                check_field("modal_bin", want_result.modal_bin, got_result.modal_bin);
            end
        end
    end

    task automatic queue_item(input logic [1:0] kind, input logic [13:0] blk,
                              input logic [15:0] loud, input logic [6:0] sel);
        meter_item_t it;
        it.kind = kind;
        it.blk = blk;
        it.loud = loud;
        it.sel = sel;
        pending_items.push_back(it);
    endtask

    // Random item: mostly audio blocks sized to the period, loudness clustered
    // around a few bins so that ties for the peak show up
    task automatic queue_random_item(input int period, input int clear_odds);
        logic [1:0]  k;
        logic [13:0] blk;
        logic [15:0] loud;
        logic [6:0]  sel;
        int          roll;
        int          span;
        int          b;
        blk = 14'($urandom);
        loud = 16'($urandom);
        sel = 7'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < clear_odds)
            k = KIND_CLEAR;
        else if (roll < clear_odds + 3)
            k = KIND_SPARE;
        else if (roll < 38)
        begin
            k = KIND_READ;
            if ($urandom_range(0, 7) != 0)
                sel = 7'($urandom_range(0, NUM_BINS - 1));
        end
        else
        begin
            k = KIND_AUDIO;
            span = (period < 1) ? 1 : period;
            if (period >= 64)
            begin
                // large periods: any block size, oversized ones included
                if ($urandom_range(0, 9) != 0)
                    blk = 14'($urandom_range(0, (2 * span > 16383) ? 16383 : 2 * span));
            end
            else if ($urandom_range(0, 29) == 0)
                blk = 14'($urandom_range(200, 700));
            else
                blk = 14'($urandom_range(0, 3 * span));
            if ($urandom_range(0, 7) != 0)
            begin
                b = cluster_bin + int'($urandom_range(0, 4));
                loud = 16'((b - 70) * 16 + int'($urandom_range(0, 15)) - 8);
            end
        end
        queue_item(k, blk, loud, sel);
    endtask

    task automatic wait_drained;
        @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_period(input int value);
        // block is idle here; let it settle before the register moves
        repeat (8) @(negedge clk);
        cfg_data <= 16'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Stimulus
    initial
    begin
        int phase_periods [10];
        int last_phase;
        tick_period = int'(SPT_RESET);
        ring_phase = 0;
        ring_slot = 0;
        ring_fill = 0;
        peak_tally = 0;
        peak_at = 0;
        foreach (tally[i])
            tally[i] = 0;
        foreach (ring_bins[i])
            ring_bins[i] = '0;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty histogram reads, including a bin past the top
        queue_item(KIND_READ, 14'($urandom), 16'($urandom), 7'd0);
        queue_item(KIND_READ, 14'($urandom), 16'($urandom), TOP_BIN);
        queue_item(KIND_READ, 14'($urandom), 16'($urandom), 7'd127);
        // one sample short of a period, then the period completes
        queue_item(KIND_AUDIO, 14'd4799, 16'h0000, 7'($urandom));
        queue_item(KIND_AUDIO, 14'd1, 16'h8000, 7'($urandom));
        // oversized block, then an empty one, then two periods in one block
        queue_item(KIND_AUDIO, 14'd16383, 16'h7fff, 7'($urandom));
        queue_item(KIND_AUDIO, 14'd0, 16'h0000, 7'($urandom));
        queue_item(KIND_AUDIO, 14'd8192, 16'hfff8, 7'($urandom));
        // rounding at half steps and just below the bottom bin
        queue_item(KIND_AUDIO, 14'd4800, 16'(-1128), 7'($urandom));
        queue_item(KIND_AUDIO, 14'd4800, 16'(-1112), 7'($urandom));
        queue_item(KIND_AUDIO, 14'd4800, 16'(-1121), 7'($urandom));
        queue_item(KIND_AUDIO, 14'd4800, 16'd24, 7'($urandom));
        queue_item(KIND_AUDIO, 14'd4800, 16'(-1104), 7'($urandom));
        queue_item(KIND_READ, 14'($urandom), 16'($urandom), 7'd0);
        queue_item(KIND_READ, 14'($urandom), 16'($urandom), 7'd1);
        queue_item(KIND_READ, 14'($urandom), 16'($urandom), TOP_BIN);
        queue_item(KIND_READ, 14'($urandom), 16'($urandom), 7'd71);
        // clear keeps the histogram until the next rebuild; kind 3 does nothing
        queue_item(KIND_CLEAR, 14'($urandom), 16'($urandom), 7'($urandom));
        queue_item(KIND_READ, 14'($urandom), 16'($urandom), TOP_BIN);
        queue_item(KIND_SPARE, 14'($urandom), 16'($urandom), 7'($urandom));
        queue_item(KIND_AUDIO, 14'd4800, 16'h0000, 7'($urandom));
        queue_item(KIND_AUDIO, 14'd100, 16'h0000, 7'($urandom));
        wait_drained();

        // period lowered under the current phase: next sample records
        write_period(1);
        queue_item(KIND_AUDIO, 14'd1, 16'(-560), 7'($urandom));
        wait_drained();

        // zero period: every sample records; ring wraps and one bin holds all
        write_period(0);
        queue_item(KIND_AUDIO, 14'd600, 16'h0000, 7'($urandom));
        queue_item(KIND_READ, 14'($urandom), 16'($urandom), TOP_BIN);
        queue_item(KIND_AUDIO, 14'd3, 16'(-1000), 7'($urandom));
        wait_drained();

        // Random phases over a spread of periods
        phase_periods = '{2, 65535, 0, 1, 4800, $urandom_range(3, 40),
                          $urandom_range(41, 5000), $urandom_range(1, 65535), 7, 1};
        last_phase = $size(phase_periods) - 1;
        foreach (phase_periods[ph])
        begin
            write_period(phase_periods[ph]);
            gaps_on = (ph != 4) && (ph != last_phase);
            cluster_bin = $urandom_range(0, 66);
            repeat (100)
                queue_random_item(phase_periods[ph], (ph == 3) ? 0 : 3);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            fail_count++;
        end
        $display("Covered %0d items over %0d period settings: %0d rebuilds, %0d bin reads, %0d clears",
                 items_seen, settings_used, rebuilds_seen, reads_seen, clears_seen);
        $display("History filled to %0d slots, largest peak count %0d", deepest_fill, top_peak);
        if (fail_count == 0)
            $display("loudness_history_histogram regression: pass");
        else
            $display("loudness_history_histogram regression: fail");
        $finish;
    end

    // Hang guard
    initial
    begin
        #100000000;
        $display("loudness_history_histogram regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/lhh_pkg.sv
rtl/loudness_history_histogram.sv
tb/tb_loudness_history_histogram.sv
